[rtl/ncr_pkg.sv]
// ncr_pkg: shared constants and helper functions for the newton cubic root classifier
// used by ncr_mul, ncr_div and newton_cubic_root_classifier_core
package ncr_pkg;

  localparam int FRAC_BITS  = 28;
  localparam int BASE_ITERS = 60;
  localparam int MAX_EXTRA  = 20;
  localparam int ZOOM_LIMIT = 40;
  localparam int ZOOM_W     = 11;
  localparam int ITER_W     = 9;
  localparam int DIV_W      = 64 + FRAC_BITS;
  localparam int DIV_CNT_W  = $clog2(DIV_W + 1);

  localparam logic signed [63:0] FX_LIM       = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] FX_LIM_THIRD = FX_LIM / 3;
  localparam logic signed [63:0] FX_ONE       = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] FX_HALF      = FX_ONE >>> 1;
  localparam logic [63:0]        SQRT3_HALF_Q64 = 64'hDDB3_D742_C265_539D;
  localparam logic signed [63:0] FX_S3 =
    $signed(((SQRT3_HALF_Q64 >> (63 - FRAC_BITS)) + 64'd1) >> 1);

  localparam logic [2:0] ROOT_ONE   = 3'd0;
  localparam logic [2:0] ROOT_UPPER = 3'd1;
  localparam logic [2:0] ROOT_LOWER = 3'd2;
  localparam logic [2:0] ROOT_EQUAL = 3'd3;
  localparam logic [2:0] ROOT_NONE  = 3'd4;

  localparam logic [23:0] COL_RED    = 24'hFF0000;
  localparam logic [23:0] COL_BLUE   = 24'h0000FF;
  localparam logic [23:0] COL_GREEN  = 24'h00FF00;
  localparam logic [23:0] COL_YELLOW = 24'hFFFF00;
  localparam logic [23:0] COL_BLACK  = 24'h000000;

  function automatic logic [23:0] root_colour(input logic [2:0] idx);
    logic [23:0] c;
    case (idx)
      ROOT_ONE:   c = COL_RED;
      ROOT_UPPER: c = COL_BLUE;
      ROOT_LOWER: c = COL_GREEN;
      ROOT_EQUAL: c = COL_YELLOW;
      default:    c = COL_BLACK;
    endcase
    return c;
  endfunction

  function automatic logic signed [63:0] sat_lim(input logic signed [64:0] v);
    logic signed [64:0] hi;
    logic signed [64:0] lo;
    logic signed [63:0] r;
    hi = 65'(FX_LIM);
    lo = -hi;
    if (v > hi) r = FX_LIM;
    else if (v < lo) r = -FX_LIM;
    else r = v[63:0];
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
    logic signed [64:0] hi;
    logic signed [64:0] lo;
    logic signed [31:0] r;
    hi = 65'sd2147483647;
    lo = -65'sd2147483648;
    if (v > hi) r = 32'sh7FFF_FFFF;
    else if (v < lo) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

[rtl/ncr_mul.sv]
// ncr_mul: fixed-point signed multiplier, product >> FRAC_BITS with saturation
// four 32x32 partial products accumulated in turn; depends on ncr_pkg
module ncr_mul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] a_i,
  input  logic signed [63:0] b_i,
  output logic               busy_o,
  output logic               done_o,
  output logic signed [63:0] res_o
);

  logic [63:0]  ua_q, ub_q;
  logic         neg_q;
  logic [127:0] acc_q;
  logic [1:0]   cnt_q;
  logic         busy_q, done_q;

  logic [31:0]  a_part, b_part;
  logic [63:0]  prod;
  logic [127:0] prod_sh;
  logic         sat_hi;
  logic [63:0]  mag;

  always_comb begin
    a_part = cnt_q[0] ? ua_q[63:32] : ua_q[31:0];
    b_part = cnt_q[1] ? ub_q[63:32] : ub_q[31:0];
    prod   = 64'(a_part) * 64'(b_part);
    case (cnt_q)
      2'd0:    prod_sh = {64'd0, prod};
      2'd3:    prod_sh = {prod, 64'd0};
      default: prod_sh = {32'd0, prod, 32'd0};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= 2'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      ua_q  <= a_i[63] ? 64'(-a_i) : 64'(a_i);
      ub_q  <= b_i[63] ? 64'(-b_i) : 64'(b_i);
      neg_q <= a_i[63] ^ b_i[63];
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_q + prod_sh;
    end
  end

  // anything at or above 2^62 after the shift saturates
  assign sat_hi = |acc_q[127:62+ncr_pkg::FRAC_BITS];
  assign mag    = sat_hi ? 64'(ncr_pkg::FX_LIM)
                         : {2'b00, acc_q[61+ncr_pkg::FRAC_BITS:ncr_pkg::FRAC_BITS]};
  assign res_o  = neg_q ? -$signed(mag) : $signed(mag);
  assign busy_o = busy_q;
  assign done_o = done_q;

endmodule

[rtl/ncr_div.sv]
// ncr_div: restoring divider for (num << FRAC_BITS) / den, one quotient bit per cycle
// truncates toward zero and saturates; depends on ncr_pkg
module ncr_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] num_i,
  input  logic [62:0]        den_i,
  output logic               busy_o,
  output logic               done_o,
  output logic signed [63:0] res_o
);

  localparam int DW = ncr_pkg::DIV_W;
  localparam int CW = ncr_pkg::DIV_CNT_W;

  logic [DW-1:0] dvd_q, quo_q;
  logic [62:0]   den_q, rem_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q, neg_q;

  logic [63:0]   trial;
  logic          ge;
  logic [63:0]   nmag;
  logic [63:0]   mag;

  always_comb begin
    trial = {rem_q, dvd_q[DW-1]};
    ge    = trial >= {1'b0, den_q};
    nmag  = num_i[63] ? 64'(-num_i) : 64'(num_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(DW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      dvd_q <= {nmag, {ncr_pkg::FRAC_BITS{1'b0}}};
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= '0;
      neg_q <= num_i[63];
    end else if (busy_q) begin
      rem_q <= ge ? 63'(trial - {1'b0, den_q}) : trial[62:0];
      quo_q <= {quo_q[DW-2:0], ge};
      dvd_q <= {dvd_q[DW-2:0], 1'b0};
    end
  end

  assign mag    = (|quo_q[DW-1:62]) ? 64'(ncr_pkg::FX_LIM) : {2'b00, quo_q[61:0]};
  assign res_o  = neg_q ? -$signed(mag) : $signed(mag);
  assign busy_o = busy_q;
  assign done_o = done_q;

endmodule

[rtl/newton_cubic_root_classifier_core.sv]
// newton_cubic_root_classifier_core: newton iteration for z^3-1 on one pixel, then root pick
// each newton step does five multiplies on ncr_mul and two divides on ncr_div; 60 to 80
// steps, plus six multiplies on ncr_mul for the final distances
// one pixel at a time: in_ready_o is high only while idle, after the result is accepted
// rst_ni (async, active low) clears the sequencer, the output valid and zoom_q to 0
module newton_cubic_root_classifier_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic signed [10:0] cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] start_re_i,
  input  logic signed [31:0] start_im_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         root_index_o,
  output logic [23:0]        pixel_colour_o
);

  typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_WAIT, ST_OUT} state_e;
  typedef enum logic [3:0] {
    SP_XX, SP_YY, SP_XY, SP_WRWR, SP_WIWI, SP_DVR, SP_DVI,
    SP_F0A, SP_F0B, SP_F1A, SP_F1B, SP_F2A, SP_F2B
  } step_e;

  state_e state_q;
  step_e  step_q;

  logic signed [ncr_pkg::ZOOM_W-1:0] zoom_q;
  logic signed [31:0] x_q, y_q;
  logic signed [63:0] t_q, wr_q, wi_q, q_q, d0_q, d1_q;
  logic [62:0]        den_q;
  logic signed [32:0] xt_q, yt_q;
  logic [ncr_pkg::ITER_W-1:0] iters_q, cnt_q;
  logic [2:0]  idx_q;
  logic [23:0] col_q;

  logic               mul_start, div_start, mul_busy, div_busy, mul_done, div_done;
  logic signed [63:0] mul_a, mul_b, div_num, mul_res, div_res, res;
  logic               is_div, unit_done;
  logic signed [63:0] xe, ye, dr0, drh, di1, di2, sum;
  logic [11:0]        zabs;
  logic [ncr_pkg::ITER_W-1:0] iters_new;
  logic signed [32:0] xt_d, yt_d;
  logic [2:0]         cls;

  function automatic logic signed [32:0] third(input logic signed [33:0] v);
    logic [33:0] m;
    logic [65:0] p;
    logic [32:0] q;
    m = v[33] ? 34'(-v) : 34'(v);
    // floor(m/3) for m < 2^33 via reciprocal 0xAAAAAAAB / 2^33
    p = 66'(m[32:0]) * 66'h0_AAAA_AAAB;
    q = p[65:33];
    return v[33] ? -$signed(q) : $signed(q);
  endfunction

  always_comb begin
    xe  = 64'(x_q);
    ye  = 64'(y_q);
    dr0 = ncr_pkg::FX_ONE - xe;
    drh = -xe - ncr_pkg::FX_HALF;
    di1 = ncr_pkg::FX_S3 - ye;
    di2 = -ye - ncr_pkg::FX_S3;
    xt_d = third(34'(x_q) <<< 1);
    yt_d = third(34'(y_q) <<< 1);

    is_div = (step_q == SP_DVR) || (step_q == SP_DVI);
    case (step_q)
      SP_XX:   begin mul_a = xe;        mul_b = xe;   end
      SP_YY:   begin mul_a = ye;        mul_b = ye;   end
      SP_XY:   begin mul_a = xe <<< 1;  mul_b = ye;   end
      SP_WRWR: begin mul_a = wr_q;      mul_b = wr_q; end
      SP_WIWI: begin mul_a = wi_q;      mul_b = wi_q; end
      SP_F0A:  begin mul_a = dr0;       mul_b = dr0;  end
      SP_F0B:  begin mul_a = ye;        mul_b = ye;   end
      SP_F1A:  begin mul_a = drh;       mul_b = drh;  end
      SP_F1B:  begin mul_a = di1;       mul_b = di1;  end
      SP_F2A:  begin mul_a = drh;       mul_b = drh;  end
      SP_F2B:  begin mul_a = di2;       mul_b = di2;  end
      default: begin mul_a = xe;        mul_b = xe;   end
    endcase
    div_num   = (step_q == SP_DVI) ? -wi_q : wr_q;
    mul_start = (state_q == ST_ISSUE) && !is_div;
    div_start = (state_q == ST_ISSUE) && is_div;
    unit_done = is_div ? div_done : mul_done;
    res       = is_div ? div_res : mul_res;
    sum       = ncr_pkg::sat_lim(65'(t_q) + 65'(res));

    zabs      = zoom_q[ncr_pkg::ZOOM_W-1] ? 12'(-13'(zoom_q)) : 12'(zoom_q);
    iters_new = ncr_pkg::ITER_W'(ncr_pkg::BASE_ITERS) +
                ((zabs <= 12'(ncr_pkg::ZOOM_LIMIT)) ? ncr_pkg::ITER_W'(zabs >> 1)
                                                    : ncr_pkg::ITER_W'(ncr_pkg::MAX_EXTRA));

    // sum holds d2 during the last final step
    if (d0_q < d1_q && d0_q < sum) cls = ncr_pkg::ROOT_ONE;
    else if (d1_q < d0_q && d1_q < sum) cls = ncr_pkg::ROOT_UPPER;
    else if (sum < d0_q && sum < d1_q) cls = ncr_pkg::ROOT_LOWER;
    else if (d0_q == d1_q && d1_q == sum) cls = ncr_pkg::ROOT_EQUAL;
    else cls = ncr_pkg::ROOT_NONE;
  end

  ncr_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .busy_o  (mul_busy),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  ncr_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (den_q),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .res_o   (div_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= SP_XX;
      zoom_q  <= '0;
      cnt_q   <= '0;
      iters_q <= '0;
      idx_q   <= ncr_pkg::ROOT_NONE;
      col_q   <= ncr_pkg::COL_BLACK;
    end else begin
      if (cfg_we_i) zoom_q <= cfg_wdata_i;
      xt_q <= xt_d;
      yt_q <= yt_d;
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            x_q     <= start_re_i;
            y_q     <= start_im_i;
            iters_q <= iters_new;
            cnt_q   <= '0;
            step_q  <= SP_XX;
            state_q <= ST_ISSUE;
          end
        end
        ST_ISSUE: state_q <= ST_WAIT;
        ST_WAIT: begin
          if (unit_done) begin
            state_q <= ST_ISSUE;
            case (step_q)
              SP_XX:   begin t_q <= res; step_q <= SP_YY; end
              SP_YY: begin
                wr_q   <= ncr_pkg::sat_lim(65'(t_q) - 65'(res));
                step_q <= SP_XY;
              end
              SP_XY:   begin wi_q <= res; step_q <= SP_WRWR; end
              SP_WRWR: begin t_q <= res; step_q <= SP_WIWI; end
              SP_WIWI: begin
                if (sum == 64'sd0) begin
                  // |z^2|^2 vanished: no newton step possible
                  idx_q   <= ncr_pkg::ROOT_NONE;
                  col_q   <= ncr_pkg::COL_BLACK;
                  state_q <= ST_OUT;
                end else begin
                  den_q  <= (sum > ncr_pkg::FX_LIM_THIRD) ? 63'(ncr_pkg::FX_LIM)
                                                          : 63'(sum + (sum <<< 1));
                  step_q <= SP_DVR;
                end
              end
              SP_DVR:  begin q_q <= res; step_q <= SP_DVI; end
              SP_DVI: begin
                x_q   <= ncr_pkg::sat32(65'(xt_q) + 65'(q_q));
                y_q   <= ncr_pkg::sat32(65'(yt_q) + 65'(res));
                cnt_q <= cnt_q + 1'b1;
                step_q <= (cnt_q + 1'b1 == iters_q) ? SP_F0A : SP_XX;
              end
              SP_F0A:  begin t_q <= res; step_q <= SP_F0B; end
              SP_F0B:  begin d0_q <= sum; step_q <= SP_F1A; end
              SP_F1A:  begin t_q <= res; step_q <= SP_F1B; end
              SP_F1B:  begin d1_q <= sum; step_q <= SP_F2A; end
              SP_F2A:  begin t_q <= res; step_q <= SP_F2B; end
              SP_F2B: begin
                idx_q   <= cls;
                col_q   <= ncr_pkg::root_colour(cls);
                state_q <= ST_OUT;
              end
              default: state_q <= ST_IDLE;
            endcase
          end
        end
        ST_OUT: begin
          if (out_ready_i) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o     = (state_q == ST_IDLE);
  assign out_valid_o    = (state_q == ST_OUT);
  assign root_index_o   = idx_q;
  assign pixel_colour_o = col_q;

  a_out_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("input taken while result pending");

  a_none_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && root_index_o == ncr_pkg::ROOT_NONE) |-> pixel_colour_o == 24'h0)
    else $error("undecided pixel not black");

  a_idle_units: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (!mul_busy && !div_busy))
    else $error("arithmetic unit busy while idle");

  a_one_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mul_busy && div_busy)) else $error("both units busy");

endmodule
